[hdl/gtwr_pkg.sv]
// shared types and constants of the greedy time-weighted route builder
// no dependencies; imported by every module of the block but gtwr_ram

package gtwr_pkg;

	// defaults for the top-level parameters
	localparam int MAX_NODES_DEF  = 32;
	localparam int MAX_TRUCKS_DEF = 8;
	localparam int DIST_BITS_DEF  = 16;

	// fixed field widths
	localparam int CMD_W   = 2;
	localparam int ROW_W   = 5;
	localparam int VAL_W   = 16;
	localparam int ID_W    = 6;
	localparam int NCNT_W  = 6;
	localparam int TCNT_W  = 4;
	localparam int PACE_W  = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// input item commands
	localparam logic [CMD_W-1:0] CMD_LOAD_NODE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_DIST = 2'd1;
	localparam logic [CMD_W-1:0] CMD_START     = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRUCK_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPOT_NODE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PACE        = 2'd3;

	// configuration reset values
	localparam logic [NCNT_W-1:0] NODE_COUNT_RST  = 6'd32;
	localparam logic [TCNT_W-1:0] TRUCK_COUNT_RST = 4'd1;
	localparam logic [NCNT_W-1:0] DEPOT_NODE_RST  = 6'd1;
	localparam logic [PACE_W-1:0] PACE_RST        = 16'd256;

	// what an emitted item carries
	typedef logic [1:0] emit_sel_t;
	localparam emit_sel_t EMIT_DEPOT = 2'd0;
	localparam emit_sel_t EMIT_BEST  = 2'd1;
	localparam emit_sel_t EMIT_SEP   = 2'd2;
	localparam emit_sel_t EMIT_EMPTY = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic             load_node;
		logic             load_dist;
		logic             start;
		logic             issue;
		logic             clear_best;
		logic             emit;
		emit_sel_t        emit_sel;
		logic             emit_last;
		logic [ID_W-1:0]  depot_id;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pipe_busy;
		logic found;
		logic out_free;
	} dp_status_t;

endpackage

[hdl/gtwr_ram.sv]
// generic simple dual-port ram: one write port, one registered read port
// no dependencies

module gtwr_ram #(
	parameter int WIDTH  = 16,
	parameter int DEPTH  = 32,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/gtwr_cfg.sv]
// configuration register bank of the route builder
// depends on gtwr_pkg

module gtwr_cfg import gtwr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [NCNT_W-1:0]     node_count,
	output logic [TCNT_W-1:0]     truck_count,
	output logic [NCNT_W-1:0]     depot_node,
	output logic [PACE_W-1:0]     pace
);

	logic [NCNT_W-1:0] node_count_q;
	logic [TCNT_W-1:0] truck_count_q;
	logic [NCNT_W-1:0] depot_node_q;
	logic [PACE_W-1:0] pace_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q  <= NODE_COUNT_RST;
			truck_count_q <= TRUCK_COUNT_RST;
			depot_node_q  <= DEPOT_NODE_RST;
			pace_q        <= PACE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_NODE_COUNT:  node_count_q  <= cfg_data[NCNT_W-1:0];
				CFG_TRUCK_COUNT: truck_count_q <= cfg_data[TCNT_W-1:0];
				CFG_DEPOT_NODE:  depot_node_q  <= cfg_data[NCNT_W-1:0];
				CFG_PACE:        pace_q        <= cfg_data[PACE_W-1:0];
				default: ;
			endcase
		end
	end

	assign node_count  = node_count_q;
	assign truck_count = truck_count_q;
	assign depot_node  = depot_node_q;
	assign pace        = pace_q;

endmodule

[hdl/gtwr_dpath.sv]
// datapath of the route builder: stores, candidate scan pipeline, best tracker, output register
// depends on gtwr_pkg and gtwr_ram

module gtwr_dpath import gtwr_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int DIST_BITS = DIST_BITS_DEF,
	parameter int NODE_W    = $clog2(MAX_NODES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	input  logic [NODE_W-1:0] issue_idx,
	input  logic [NODE_W-1:0] start_idx,
	input  logic [PACE_W-1:0] pace,
	input  logic [ROW_W-1:0]  row_index,
	input  logic [ROW_W-1:0]  col_index,
	input  logic [VAL_W-1:0]  value,
	input  logic              eligible,
	output dp_status_t        status,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ID_W-1:0]   out_node_id,
	output logic              out_last,
	output logic              out_empty
);

	localparam int ADDR_W = $clog2(MAX_NODES * MAX_NODES);
	localparam int EXT_W  = (NODE_W > ROW_W) ? NODE_W : ROW_W;
	localparam int PROD_W = DIST_BITS + PACE_W;
	localparam int WGT_W  = DIST_BITS + PACE_W + 1;

	logic [EXT_W-1:0]  row_ext, col_ext;
	logic [NODE_W-1:0] row_n, col_n;
	logic              row_ok, col_ok;
	logic [ADDR_W-1:0] dist_waddr, dist_raddr;
	logic [DIST_BITS-1:0] dist_rd;
	logic [VAL_W-1:0]  ready_rd;

	logic [MAX_NODES-1:0] elig_q, visited_q;
	logic [NODE_W-1:0]    cur_q;

	logic              iss_v_s1, cand_s1;
	logic [NODE_W-1:0] idx_s1;
	logic              v_s2;
	logic [NODE_W-1:0] idx_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [VAL_W-1:0]  rdy_s2;
	logic [WGT_W-1:0]  weight;

	logic              found_q;
	logic [WGT_W-1:0]  best_w_q;
	logic [NODE_W-1:0] best_idx_q;

	logic              out_valid_q;
	logic [ID_W-1:0]   out_id_q;
	logic              out_last_q, out_empty_q;
	logic [ID_W-1:0]   emit_id;
	logic              emit_best;

	// load addressing, out-of-range loads are dropped
	assign row_ext = EXT_W'(row_index);
	assign col_ext = EXT_W'(col_index);
	assign row_n   = row_ext[NODE_W-1:0];
	assign col_n   = col_ext[NODE_W-1:0];
	assign row_ok  = 32'(row_index) < MAX_NODES;
	assign col_ok  = 32'(col_index) < MAX_NODES;

	assign dist_waddr = ADDR_W'(row_n) * ADDR_W'(MAX_NODES) + ADDR_W'(col_n);
	assign dist_raddr = ADDR_W'(cur_q) * ADDR_W'(MAX_NODES) + ADDR_W'(issue_idx);

	gtwr_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_NODES * MAX_NODES)) u_dist_ram (
		.clk   (clk),
		.we    (cmd.load_dist & row_ok & col_ok),
		.waddr (dist_waddr),
		.wdata (DIST_BITS'(value)),
		.raddr (dist_raddr),
		.rdata (dist_rd)
	);

	gtwr_ram #(.WIDTH(VAL_W), .DEPTH(MAX_NODES)) u_ready_ram (
		.clk   (clk),
		.we    (cmd.load_node & row_ok),
		.waddr (row_n),
		.wdata (value),
		.raddr (issue_idx),
		.rdata (ready_rd)
	);

	assign emit_best = cmd.emit && (cmd.emit_sel == EMIT_BEST);

	// node flags and walk position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elig_q    <= '0;
			visited_q <= '0;
			cur_q     <= '0;
		end else begin
			if (cmd.load_node && row_ok) begin
				elig_q[row_n] <= eligible;
			end
			if (cmd.start) begin
				visited_q <= '0;
				cur_q     <= start_idx;
			end else if (emit_best) begin
				visited_q[best_idx_q] <= 1'b1;
				cur_q                 <= best_idx_q;
			end
		end
	end

	// scan pipeline: read, multiply, weigh and compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_v_s1 <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			iss_v_s1 <= cmd.issue;
			v_s2     <= iss_v_s1 & cand_s1;
		end
	end

	always_ff @(posedge clk) begin
		cand_s1 <= elig_q[issue_idx] & ~visited_q[issue_idx];
		idx_s1  <= issue_idx;
		idx_s2  <= idx_s1;
		prod_s2 <= PROD_W'(dist_rd) * PROD_W'(pace);
		rdy_s2  <= ready_rd;
	end

	assign weight = WGT_W'(prod_s2) + WGT_W'({rdy_s2, 8'h00});

	// strict less-than keeps the lowest index on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.clear_best) begin
			found_q <= 1'b0;
		end else if (v_s2 && (!found_q || weight < best_w_q)) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd.clear_best && v_s2 && (!found_q || weight < best_w_q)) begin
			best_w_q   <= weight;
			best_idx_q <= idx_s2;
		end
	end

	// output register
	always_comb begin
		unique case (cmd.emit_sel)
			EMIT_DEPOT: emit_id = cmd.depot_id;
			EMIT_BEST:  emit_id = ID_W'(32'(best_idx_q) + 1);
			default:    emit_id = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_id_q    <= emit_id;
			out_last_q  <= cmd.emit_last;
			out_empty_q <= (cmd.emit_sel == EMIT_EMPTY);
		end
	end

	assign out_valid   = out_valid_q;
	assign out_node_id = out_id_q;
	assign out_last    = out_last_q;
	assign out_empty   = out_empty_q;

	assign status.pipe_busy = iss_v_s1 | v_s2;
	assign status.found     = found_q;
	assign status.out_free  = ~out_valid_q | out_ready;

endmodule

[hdl/gtwr_ctrl.sv]
// controller of the route builder: command decode, scan sequencing, item emission order
// depends on gtwr_pkg

module gtwr_ctrl import gtwr_pkg::*; #(
	parameter int MAX_NODES  = MAX_NODES_DEF,
	parameter int MAX_TRUCKS = MAX_TRUCKS_DEF,
	parameter int NODE_W     = $clog2(MAX_NODES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CMD_W-1:0]  in_cmd,
	input  logic [NCNT_W-1:0] node_count,
	input  logic [TCNT_W-1:0] truck_count,
	input  logic [NCNT_W-1:0] depot_node,
	input  dp_status_t        status,
	output dp_cmd_t           cmd,
	output logic [NODE_W-1:0] issue_idx,
	output logic [NODE_W-1:0] start_idx
);

	localparam int CNT_W = $clog2(MAX_NODES + 1);
	localparam int TRK_W = $clog2(MAX_TRUCKS + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_HEAD = 3'd2;
	localparam logic [2:0] ST_NODE = 3'd3;
	localparam logic [2:0] ST_TAIL = 3'd4;
	localparam logic [2:0] ST_SEP  = 3'd5;
	localparam logic [2:0] ST_NONE = 3'd6;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] n_q, n_d, n_clamp;
	logic [TRK_W-1:0] trucks_q, trucks_d, trk_clamp;
	logic [CNT_W-1:0] depot_q, depot_d, depot_clamp;
	logic [CNT_W-1:0] scan_cnt_q, scan_cnt_d;
	logic [TRK_W-1:0] sep_cnt_q, sep_cnt_d;
	logic             any_q, any_d;
	logic             accept, scan_done, one_truck;

	// clamp the registers to what the stores hold
	always_comb begin
		if (32'(node_count) > MAX_NODES) begin
			n_clamp = CNT_W'(MAX_NODES);
		end else begin
			n_clamp = CNT_W'(node_count);
		end
		if (32'(truck_count) > MAX_TRUCKS) begin
			trk_clamp = TRK_W'(MAX_TRUCKS);
		end else begin
			trk_clamp = TRK_W'(truck_count);
		end
		if (depot_node == '0) begin
			depot_clamp = CNT_W'(1);
		end else if (32'(depot_node) > MAX_NODES) begin
			depot_clamp = CNT_W'(MAX_NODES);
		end else begin
			depot_clamp = CNT_W'(depot_node);
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid & in_ready;
	assign scan_done = (scan_cnt_q >= n_q) && !status.pipe_busy;
	assign one_truck = (trucks_q <= TRK_W'(1));
	assign issue_idx = scan_cnt_q[NODE_W-1:0];
	assign start_idx = NODE_W'(depot_clamp - CNT_W'(1));

	always_comb begin
		state_d    = state_q;
		n_d        = n_q;
		trucks_d   = trucks_q;
		depot_d    = depot_q;
		scan_cnt_d = scan_cnt_q;
		sep_cnt_d  = sep_cnt_q;
		any_d      = any_q;

		cmd            = '0;
		cmd.emit_sel   = EMIT_SEP;
		cmd.depot_id   = ID_W'(depot_q);

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (in_cmd)
						CMD_LOAD_NODE: cmd.load_node = 1'b1;
						CMD_LOAD_DIST: cmd.load_dist = 1'b1;
						CMD_START: begin
							cmd.start      = 1'b1;
							cmd.clear_best = 1'b1;
							n_d        = n_clamp;
							trucks_d   = trk_clamp;
							depot_d    = depot_clamp;
							scan_cnt_d = '0;
							any_d      = 1'b0;
							// no trucks: nothing to build, only the empty marker
							state_d    = (trk_clamp == '0) ? ST_NONE : ST_SCAN;
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_cnt_q < n_q) begin
					cmd.issue  = 1'b1;
					scan_cnt_d = scan_cnt_q + CNT_W'(1);
				end else if (scan_done) begin
					if (status.found) begin
						state_d = any_q ? ST_NODE : ST_HEAD;
					end else if (any_q) begin
						state_d = ST_TAIL;
					end else if (one_truck) begin
						state_d = ST_NONE;
					end else begin
						sep_cnt_d = trucks_q - TRK_W'(1);
						state_d   = ST_SEP;
					end
				end
			end
			ST_HEAD: begin
				// depot opens the route once a first node is known
				if (status.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EMIT_DEPOT;
					state_d      = ST_NODE;
				end
			end
			ST_NODE: begin
				if (status.out_free) begin
					cmd.emit       = 1'b1;
					cmd.emit_sel   = EMIT_BEST;
					cmd.clear_best = 1'b1;
					any_d          = 1'b1;
					scan_cnt_d     = '0;
					state_d        = ST_SCAN;
				end
			end
			ST_TAIL: begin
				if (status.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = EMIT_DEPOT;
					cmd.emit_last = one_truck;
					sep_cnt_d     = trucks_q - TRK_W'(1);
					state_d       = one_truck ? ST_IDLE : ST_SEP;
				end
			end
			ST_SEP: begin
				if (status.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = EMIT_SEP;
					cmd.emit_last = (sep_cnt_q == TRK_W'(1));
					sep_cnt_d     = sep_cnt_q - TRK_W'(1);
					if (sep_cnt_q == TRK_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_NONE: begin
				if (status.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = EMIT_EMPTY;
					cmd.emit_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			n_q        <= '0;
			trucks_q   <= '0;
			depot_q    <= '0;
			scan_cnt_q <= '0;
			sep_cnt_q  <= '0;
			any_q      <= 1'b0;
		end else begin
			state_q    <= state_d;
			n_q        <= n_d;
			trucks_q   <= trucks_d;
			depot_q    <= depot_d;
			scan_cnt_q <= scan_cnt_d;
			sep_cnt_q  <= sep_cnt_d;
			any_q      <= any_d;
		end
	end

endmodule

[hdl/greedy_time_weighted_route_builder_top.sv]
// top level of the greedy time-weighted route builder
// depends on gtwr_pkg, gtwr_cfg, gtwr_ctrl, gtwr_dpath (and gtwr_ram below it)

// Greedy route builder. Load items (node data, distance entries) are taken one per
// cycle while idle and written straight into the ready-time and distance memories. A
// start item walks from the depot, each time picking the unvisited eligible node with
// the least distance*pace + ready*256 (ties to the lowest index), and sends depot,
// picked nodes, depot, then one zero separator per further truck; tlast marks the
// final item. A build with no pick gives a single item with tuser set when it has at
// most one truck, else only the zero separators. Each pick scans every node in use
// through the single read port of the distance memory, one candidate per cycle. No
// input item is taken during a build. The output register takes a new item in as the
// last one is taken. The stores need no clearing pass; a node not yet loaded is
// simply not eligible.

module greedy_time_weighted_route_builder_top import gtwr_pkg::*; #(
	parameter int MAX_NODES  = MAX_NODES_DEF,
	parameter int MAX_TRUCKS = MAX_TRUCKS_DEF,
	parameter int DIST_BITS  = DIST_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input items
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [31:0]           s_axis_tdata,  // row_index[4:0], col_index[9:5], value[25:10], eligible[26], zero pad
	input  logic [CMD_W-1:0]      s_axis_tuser,  // cmd[1:0]
	// result items
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [7:0]            m_axis_tdata,  // node_id[5:0], zero pad
	output logic                  m_axis_tlast,
	output logic [0:0]            m_axis_tuser,  // empty_res[0]
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int NODE_W = $clog2(MAX_NODES);

	logic [NCNT_W-1:0] node_count, depot_node;
	logic [TCNT_W-1:0] truck_count;
	logic [PACE_W-1:0] pace;
	dp_cmd_t           dp_cmd;
	dp_status_t        dp_status;
	logic [NODE_W-1:0] issue_idx, start_idx;
	logic [ID_W-1:0]   out_node_id;
	logic              out_empty;

	// input item fields
	logic [ROW_W-1:0]  row_index, col_index;
	logic [VAL_W-1:0]  value;
	logic              eligible;

	assign row_index = s_axis_tdata[4:0];
	assign col_index = s_axis_tdata[9:5];
	assign value     = s_axis_tdata[25:10];
	assign eligible  = s_axis_tdata[26];

	// register bank, to be written by the user only while the block is idle; the block itself does not enforce this
	gtwr_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.node_count  (node_count),
		.truck_count (truck_count),
		.depot_node  (depot_node),
		.pace        (pace)
	);

	// sequencer: decode, scan passes, emission order
	gtwr_ctrl #(
		.MAX_NODES  (MAX_NODES),
		.MAX_TRUCKS (MAX_TRUCKS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_cmd      (s_axis_tuser),
		.node_count  (node_count),
		.truck_count (truck_count),
		.depot_node  (depot_node),
		.status      (dp_status),
		.cmd         (dp_cmd),
		.issue_idx   (issue_idx),
		.start_idx   (start_idx)
	);

	// memories, weight pipeline, best tracker and output register
	gtwr_dpath #(
		.MAX_NODES (MAX_NODES),
		.DIST_BITS (DIST_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.issue_idx   (issue_idx),
		.start_idx   (start_idx),
		.pace        (pace),
		.row_index   (row_index),
		.col_index   (col_index),
		.value       (value),
		.eligible    (eligible),
		.status      (dp_status),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_node_id (out_node_id),
		.out_last    (m_axis_tlast),
		.out_empty   (out_empty)
	);

	assign m_axis_tdata = {2'b00, out_node_id};
	assign m_axis_tuser = out_empty;

endmodule
